// ===== hdl/assert_macros.svh =====
// Assertion macros for the files that carry concurrent checks.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/psl_pkg.sv =====
// Types and constants for the packet sequence loss monitor.
// No dependencies; imported by the controller, datapath, divider and top level.
package psl_pkg;

    localparam logic [15:0] WIN_TICKS_RST = 16'd2000;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;
    localparam logic [16:0] RATIO_ONE     = 17'h10000;
    localparam int          QUOT_W        = 16;
    localparam int          OUT_TDATA_W   = 56;

    localparam logic OP_PKT  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic eval;
        logic close;
        logic div_start;
        logic take_quot;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close;
        logic drops_zero;
        logic span_zero;
        logic sat;
        logic div_busy;
    } t_sts;

endpackage

// ===== hdl/psl_div.sv =====
// Restoring divider producing a 16-bit quotient, one bit per cycle.
// Depends on psl_pkg; the dividend must be below the divisor.
module psl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [31:0]                 i_dividend,
    input  logic [31:0]                 i_divisor,
    output logic                        o_busy,
    output logic [psl_pkg::QUOT_W-1:0]  o_quot
);
    import psl_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [31:0]       r_rem, n_rem;
    logic [31:0]       r_div, n_div;
    logic [QUOT_W-1:0] r_quot, n_quot;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [32:0]       w_shift;
    logic [32:0]       w_diff;

    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_comb begin
        n_rem  = r_rem;
        n_div  = r_div;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_rem  = i_dividend;
            n_div  = i_divisor;
            n_quot = '0;
            n_cnt  = CNT_W'(QUOT_W);
        end else if (r_cnt != '0) begin
            // The partial remainder stays below the divisor, so it fits 32 bits.
            if (!w_diff[32]) begin
                n_rem  = w_diff[31:0];
                n_quot = {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_shift[31:0];
                n_quot = {r_quot[QUOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quot <= n_quot;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;

endmodule

// ===== hdl/psl_dp.sv =====
// Datapath of the loss monitor: tracker state, window counters and output words.
// Depends on psl_pkg and psl_div; driven by commands from psl_ctrl.
module psl_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_op,
    input  logic [31:0]         i_in_seq,
    input  psl_pkg::t_cmd       i_cmd,
    output psl_pkg::t_sts       o_sts,
    output logic                o_lost,
    output logic [31:0]         o_total,
    output logic [16:0]         o_ratio,
    output logic                o_updated
);
    import psl_pkg::*;

    logic        r_op;
    logic [31:0] r_seq;
    logic [15:0] r_win_ticks, n_win_ticks;
    logic        r_seen, n_seen;
    logic [31:0] r_last, n_last;
    logic [31:0] r_start, n_start;
    logic [31:0] r_wdrops, n_wdrops;
    logic [31:0] r_total, n_total;
    logic [16:0] r_ratio, n_ratio;
    logic [15:0] r_elapsed, n_elapsed;
    logic [31:0] r_span, n_span;
    logic        r_lost, n_lost;
    logic        r_close, n_close;
    logic        r_o_lost;
    logic [31:0] r_o_total;
    logic [16:0] r_o_ratio;
    logic        r_o_updated;

    logic [31:0]       w_gap;
    logic              w_ahead;
    logic              w_div_busy;
    logic [QUOT_W-1:0] w_quot;

    // Sequence minus last minus one, as a single add.
    assign w_gap   = r_seq + ~r_last;
    assign w_ahead = (r_seq > r_last);

    always_comb begin
        n_win_ticks = i_cfg_we ? i_cfg_wdata : r_win_ticks;
        n_seen      = r_seen;
        n_last      = r_last;
        n_start     = r_start;
        n_wdrops    = r_wdrops;
        n_total     = r_total;
        n_ratio     = r_ratio;
        n_elapsed   = r_elapsed;
        n_span      = r_span;
        n_lost      = r_lost;
        n_close     = r_close;

        if (i_cmd.eval) begin
            if (r_op == OP_TICK) begin
                n_lost  = 1'b0;
                n_close = 1'b0;
                if (r_seen && r_elapsed != TICK_MAX) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
            end else begin
                n_lost = 1'b0;
                if (!r_seen) begin
                    n_seen  = 1'b1;
                    n_start = r_seq;
                    n_span  = '0;
                end else begin
                    n_span = r_seq - r_start;
                    if (w_ahead && w_gap != '0) begin
                        n_lost   = 1'b1;
                        n_wdrops = r_wdrops + w_gap;
                        n_total  = r_total + w_gap;
                    end
                end
                n_last  = r_seq;
                n_close = (r_elapsed >= r_win_ticks);
            end
        end

        if (i_cmd.close) begin
            n_wdrops  = '0;
            n_start   = r_last;
            n_elapsed = '0;
            if (o_sts.drops_zero) begin
                n_ratio = '0;
            end else if (!o_sts.span_zero && o_sts.sat) begin
                n_ratio = RATIO_ONE;
            end
        end

        if (i_cmd.take_quot) begin
            n_ratio = {1'b0, w_quot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_ticks <= WIN_TICKS_RST;
            r_seen      <= 1'b0;
            r_last      <= '0;
            r_start     <= '0;
            r_wdrops    <= '0;
            r_total     <= '0;
            r_ratio     <= '0;
            r_elapsed   <= '0;
            r_span      <= '0;
            r_lost      <= 1'b0;
            r_close     <= 1'b0;
        end else begin
            r_win_ticks <= n_win_ticks;
            r_seen      <= n_seen;
            r_last      <= n_last;
            r_start     <= n_start;
            r_wdrops    <= n_wdrops;
            r_total     <= n_total;
            r_ratio     <= n_ratio;
            r_elapsed   <= n_elapsed;
            r_span      <= n_span;
            r_lost      <= n_lost;
            r_close     <= n_close;
        end
        if (i_cmd.load_in) begin
            r_op  <= i_in_op;
            r_seq <= i_in_seq;
        end
        if (i_cmd.load_out) begin
            r_o_lost    <= r_lost;
            r_o_total   <= r_total;
            r_o_ratio   <= r_ratio;
            r_o_updated <= r_close;
        end
    end

    psl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_wdrops),
        .i_divisor  (r_span),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    assign o_sts.close      = r_close;
    assign o_sts.drops_zero = (r_wdrops == '0);
    assign o_sts.span_zero  = (r_span == '0);
    assign o_sts.sat        = (r_wdrops >= r_span);
    assign o_sts.div_busy   = w_div_busy;

    assign o_lost    = r_o_lost;
    assign o_total   = r_o_total;
    assign o_ratio   = r_o_ratio;
    assign o_updated = r_o_updated;

endmodule

// ===== hdl/psl_ctrl.sv =====
// Controller of the loss monitor: sequences one word through evaluate,
// window close, optional division and output load. Depends on psl_pkg.
module psl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  psl_pkg::t_sts  i_sts,
    output psl_pkg::t_cmd  o_cmd
);
    import psl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_CLOSE = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_CLOSE;
            end
            ST_CLOSE: begin
                if (!i_sts.close) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.close = 1'b1;
                    // Only nonzero drops below a nonzero span need the divider.
                    if (i_sts.drops_zero || i_sts.span_zero || i_sts.sat) begin
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.take_quot = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/packet_sequence_loss_monitor_unit.sv =====
// Packet sequence loss monitor. A word enters in idle and goes through evaluate and window
// close; its result is registered at output load, after the 16-step ratio divider when it
// closes a window that needs it. A new word waits until the last is through; a held
// result stalls the next word at its output load. Synchronous active-low reset clears all
// tracker state and counters and sets the window length to 2000 ticks; no clearing pass.
// Depends on psl_pkg, psl_ctrl, psl_dp, psl_div and assert_macros.svh.
`include "assert_macros.svh"

module packet_sequence_loss_monitor_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [15:0]                         i_cfg_wdata,     // window_ticks
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,    // [31:0] sequence_req
    input  logic [0:0]                          s_axis_tuser,    // [0] operation
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [psl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,    // [31:0] total_drops,
                                                                 // [48:32] loss_rate, pad
    output logic [1:0]                          m_axis_tuser     // [0] packet_lost,
                                                                 // [1] rate_updated
);
    import psl_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_lost;
    logic [31:0] w_total;
    logic [16:0] w_ratio;
    logic        w_updated;

    psl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    psl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_op     (s_axis_tuser[0]),
        .i_in_seq    (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_lost      (w_lost),
        .o_total     (w_total),
        .o_ratio     (w_ratio),
        .o_updated   (w_updated)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 49){1'b0}}, w_ratio, w_total};
    assign m_axis_tuser = {w_updated, w_lost};

    `ASSERT_ALWAYS(a_ratio_max, i_clk, i_rst_n, !m_axis_tvalid || (m_axis_tdata[48:32] <= RATIO_ONE), "loss rate above 1.0")
    `ASSERT_NEXT(a_one_word, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word taken while one is in work")
    `ASSERT_ALWAYS(a_div_close, i_clk, i_rst_n, !w_cmd.div_start || (w_sts.close && !w_sts.sat && !w_sts.span_zero), "divider started without a window close")

endmodule
